[hdl/wce_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wce_pkg
// shared types and constants of the waveform charge extractor
// ----------------------------------------------------------------------------
package wce_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int BASELINE_W = 21;
  localparam int CHARGE_W   = 32;
  localparam int CFG_W      = 11;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  // default record length, and depth of the record queue (power of two)
  localparam int RECORD_LENGTH_DEF = 1024;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic signed [SAMPLE_W-1:0] MIN_START = 16'sd20000;
  localparam logic signed [SAMPLE_W-1:0] MAX_START = -16'sd20000;

  // register reset values
  localparam logic [CFG_W-1:0] BASE_LEN_RST  = 11'd160;
  localparam logic [CFG_W-1:0] WIN_START_RST = 11'd240;
  localparam logic [CFG_W-1:0] WIN_STOP_RST  = 11'd960;

  // register byte offsets
  localparam logic [PADDR_W-1:0] REG_BASE_LEN  = 4'h0;
  localparam logic [PADDR_W-1:0] REG_WIN_START = 4'h4;
  localparam logic [PADDR_W-1:0] REG_WIN_STOP  = 4'h8;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } wce_in_t;

  typedef struct packed {
    logic signed [BASELINE_W-1:0] baseline;
    logic signed [SAMPLE_W-1:0]   amplitude_min;
    logic signed [SAMPLE_W-1:0]   amplitude_max;
    logic signed [CHARGE_W-1:0]   charge;
  } wce_out_t;

endpackage
`default_nettype wire

[hdl/wce_intf.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wce_in_if / wce_out_if
// valid/ready channels for samples and record results
// ----------------------------------------------------------------------------
interface wce_in_if import wce_pkg::*; ();
  logic    valid;
  logic    ready;
  wce_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface wce_out_if import wce_pkg::*; ();
  logic     valid;
  logic     ready;
  wce_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/wce_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wce_front
// per-sample accumulation of min, max, baseline sum and window sum
// ----------------------------------------------------------------------------
module wce_front import wce_pkg::*; #(
  parameter int RECORD_LENGTH = RECORD_LENGTH_DEF,
  parameter int SUM_W         = 17 + $clog2(RECORD_LENGTH),
  parameter int ENT_W         = 2 * SUM_W + 2 * SAMPLE_W
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  wce_in_if.sink           samp_i,
  input  wire  [CFG_W-1:0] base_len_i,
  input  wire  [CFG_W-1:0] win_start_i,
  input  wire  [CFG_W-1:0] win_stop_i,
  input  wire              full_i,
  output logic             push_o,
  output logic [ENT_W-1:0] push_data_o
);

  localparam int IdxW = $clog2(RECORD_LENGTH + 1);
  localparam int CmpW = (IdxW > CFG_W) ? IdxW : CFG_W;

  logic [IdxW-1:0]            idx_q, idx_d;
  logic signed [SAMPLE_W-1:0] min_q, min_d, min_nx;
  logic signed [SAMPLE_W-1:0] max_q, max_d, max_nx;
  logic signed [SUM_W-1:0]    bsum_q, bsum_d, bsum_nx;
  logic signed [SUM_W-1:0]    wsum_q, wsum_d, wsum_nx;
  logic signed [SUM_W-1:0]    s_ext;
  logic signed [SAMPLE_W-1:0] s;
  logic [CmpW-1:0]            idx_c;
  logic                       active, in_base, in_win, acc;

  assign samp_i.ready = !full_i;
  assign acc          = samp_i.valid && !full_i;
  assign s            = samp_i.data.sample;
  assign s_ext        = SUM_W'(s);

  // index saturates at the record length, later samples are dropped
  assign active  = (idx_q != IdxW'(RECORD_LENGTH));
  assign idx_c   = CmpW'(idx_q);
  assign in_base = idx_c < CmpW'(base_len_i);
  assign in_win  = (idx_c >= CmpW'(win_start_i)) && (idx_c < CmpW'(win_stop_i));

  always_comb begin
    min_nx  = (active && (s < min_q)) ? s : min_q;
    max_nx  = (active && (s > max_q)) ? s : max_q;
    bsum_nx = (active && in_base) ? bsum_q + s_ext : bsum_q;
    wsum_nx = (active && in_win) ? wsum_q + s_ext : wsum_q;

    idx_d  = idx_q;
    min_d  = min_q;
    max_d  = max_q;
    bsum_d = bsum_q;
    wsum_d = wsum_q;
    if (acc) begin
      if (samp_i.data.last_sample) begin
        idx_d  = '0;
        min_d  = MIN_START;
        max_d  = MAX_START;
        bsum_d = '0;
        wsum_d = '0;
      end else begin
        idx_d  = active ? idx_q + 1'b1 : idx_q;
        min_d  = min_nx;
        max_d  = max_nx;
        bsum_d = bsum_nx;
        wsum_d = wsum_nx;
      end
    end
  end

  assign push_o      = acc && samp_i.data.last_sample;
  assign push_data_o = {bsum_nx, wsum_nx, min_nx, max_nx};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      min_q  <= MIN_START;
      max_q  <= MAX_START;
      bsum_q <= '0;
      wsum_q <= '0;
    end else begin
      idx_q  <= idx_d;
      min_q  <= min_d;
      max_q  <= max_d;
      bsum_q <= bsum_d;
      wsum_q <= wsum_d;
    end
  end

endmodule
`default_nettype wire

[hdl/wce_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wce_fifo
// short queue of finished record sums between front and back
// ----------------------------------------------------------------------------
module wce_fifo import wce_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  wire  [WIDTH-1:0] data_i,
  output logic             full_o,
  input  wire              pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/wce_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wce_back
// per-record baseline division, charge correction and result register
// ----------------------------------------------------------------------------
module wce_back import wce_pkg::*; #(
  parameter int RECORD_LENGTH = RECORD_LENGTH_DEF,
  parameter int SUM_W         = 17 + $clog2(RECORD_LENGTH),
  parameter int ENT_W         = 2 * SUM_W + 2 * SAMPLE_W
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              q_valid_i,
  input  wire  [ENT_W-1:0] q_data_i,
  output logic             q_pop_o,
  input  wire  [CFG_W-1:0] base_len_i,
  input  wire  [CFG_W-1:0] win_start_i,
  input  wire  [CFG_W-1:0] win_stop_i,
  wce_out_if.source        res_o
);

  localparam int DvW   = SUM_W + 4;
  localparam int CntW  = $clog2(DvW);
  localparam int SpanW = CFG_W + 1;
  localparam int ProdW = SpanW + BASELINE_W;
  localparam int ChW   = ((DvW > ProdW) ? DvW : ProdW) + 1;
  localparam logic signed [ChW-1:0] ChMax = ChW'(64'sd2147483647);
  localparam logic signed [ChW-1:0] ChMin = -ChMax - 1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_FIX  = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_SUB  = 6'b010000,
    ST_OUT  = 6'b100000
  } st_e;

  st_e                          st_q, st_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic [DvW-1:0]               qd_q, qd_d;
  logic [CFG_W-1:0]             r_q, r_d;
  logic                         neg_q, neg_d;
  logic signed [SUM_W-1:0]      wsum_q, wsum_d;
  logic signed [SAMPLE_W-1:0]   min_q, min_d, max_q, max_d;
  logic signed [BASELINE_W-1:0] base_q, base_d;
  logic signed [ProdW-1:0]      prod_q, prod_d;
  logic signed [CHARGE_W-1:0]   chg_q, chg_d;
  wce_out_t                     out_q, out_d;
  logic                         ov_q, ov_d;

  logic signed [SUM_W-1:0]      e_bsum, e_wsum;
  logic signed [SAMPLE_W-1:0]   e_min, e_max;
  logic signed [DvW-1:0]        dvd;
  logic [CFG_W:0]               trial, divisor;
  logic                         ge;
  logic [BASELINE_W-1:0]        qmag;
  logic signed [SpanW-1:0]      span;
  logic signed [ChW-1:0]        diff;

  assign {e_bsum, e_wsum, e_min, e_max} = q_data_i;
  assign dvd     = DvW'(e_bsum) <<< 4;
  assign divisor = {1'b0, base_len_i};
  assign trial   = {r_q, qd_q[DvW-1]};
  assign ge      = (trial >= divisor);
  assign qmag    = BASELINE_W'(qd_q);
  assign span    = signed'({1'b0, win_stop_i} - {1'b0, win_start_i});
  assign diff    = (ChW'(wsum_q) <<< 4) - ChW'(prod_q);

  assign q_pop_o     = (st_q == ST_IDLE) && q_valid_i;
  assign res_o.valid = ov_q;
  assign res_o.data  = out_q;

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    qd_d   = qd_q;
    r_d    = r_q;
    neg_d  = neg_q;
    wsum_d = wsum_q;
    min_d  = min_q;
    max_d  = max_q;
    base_d = base_q;
    prod_d = prod_q;
    chg_d  = chg_q;
    out_d  = out_q;
    ov_d   = ov_q && !res_o.ready;
    case (st_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          neg_d  = dvd[DvW-1];
          qd_d   = dvd[DvW-1] ? DvW'(-dvd) : DvW'(dvd);
          r_d    = '0;
          cnt_d  = '0;
          wsum_d = e_wsum;
          min_d  = e_min;
          max_d  = e_max;
          st_d   = ST_DIV;
        end
      end
      // restoring division, one quotient bit per cycle
      ST_DIV: begin
        r_d   = ge ? CFG_W'(trial - divisor) : CFG_W'(trial);
        qd_d  = {qd_q[DvW-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(DvW - 1)) begin
          st_d = ST_FIX;
        end
      end
      ST_FIX: begin
        if (base_len_i == '0) begin
          base_d = '0;
        end else begin
          base_d = neg_q ? -signed'(qmag) : signed'(qmag);
        end
        st_d = ST_MUL;
      end
      ST_MUL: begin
        prod_d = ProdW'(span) * ProdW'(base_q);
        st_d   = ST_SUB;
      end
      ST_SUB: begin
        if (diff > ChMax) begin
          chg_d = CHARGE_W'(ChMax);
        end else if (diff < ChMin) begin
          chg_d = CHARGE_W'(ChMin);
        end else begin
          chg_d = CHARGE_W'(diff);
        end
        st_d = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_q || res_o.ready) begin
          out_d.baseline      = base_q;
          out_d.amplitude_min = min_q;
          out_d.amplitude_max = max_q;
          out_d.charge        = chg_q;
          ov_d                = 1'b1;
          st_d                = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    qd_q   <= qd_d;
    r_q    <= r_d;
    neg_q  <= neg_d;
    wsum_q <= wsum_d;
    min_q  <= min_d;
    max_q  <= max_d;
    base_q <= base_d;
    prod_q <= prod_d;
    chg_q  <= chg_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      ov_q  <= ov_d;
    end
  end

endmodule
`default_nettype wire

[hdl/waveform_charge_extractor.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// waveform_charge_extractor
// baseline-subtracted charge integration over digitized waveform records
//
// channel   dir  handshake            payload
// samp_i    in   valid/ready          sample (s16, 1/16 mV), last_sample
// res_o     out  valid/ready          baseline, amplitude_min/max, charge
// apb       in   psel/penable/pwrite  3 registers at byte offsets 0, 4, 8
//
// samples are taken one per cycle unless the queue is full; the front sums
// them in a single adder pass; a last beat pushes the record sums into a
// two-entry queue; the back divides 16*baseline_sum by baseline_samples
// one bit per cycle and pops the next record after registering the result
// short records fill the queue and then stall the sample side; reset clears
// front and control state; the result register holds while res_o stalls
// ----------------------------------------------------------------------------
module waveform_charge_extractor import wce_pkg::*; #(
  parameter int RECORD_LENGTH = RECORD_LENGTH_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  wce_in_if.sink             samp_i,
  wce_out_if.source          res_o,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [PADDR_W-1:0] paddr,
  input  wire  [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // sums are wide enough for a full record of extreme samples
  localparam int SumW = 17 + $clog2(RECORD_LENGTH);
  localparam int EntW = 2 * SumW + 2 * SAMPLE_W;

  logic [CFG_W-1:0] base_len_q, win_start_q, win_stop_q;
  logic             wr_en;

  logic             push, full, q_valid, q_pop;
  logic [EntW-1:0]  push_data, q_data;

  // configuration registers, written on the apb access beat
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_len_q  <= BASE_LEN_RST;
      win_start_q <= WIN_START_RST;
      win_stop_q  <= WIN_STOP_RST;
    end else if (wr_en) begin
      case (paddr)
        REG_BASE_LEN:  base_len_q  <= pwdata[CFG_W-1:0];
        REG_WIN_START: win_start_q <= pwdata[CFG_W-1:0];
        REG_WIN_STOP:  win_stop_q  <= pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr)
      REG_BASE_LEN:  prdata = PDATA_W'(base_len_q);
      REG_WIN_START: prdata = PDATA_W'(win_start_q);
      REG_WIN_STOP:  prdata = PDATA_W'(win_stop_q);
      default:       prdata = '0;
    endcase
  end

  // front: running min/max and the two sums, one sample per cycle unless the queue is full
  wce_front #(
    .RECORD_LENGTH (RECORD_LENGTH),
    .SUM_W         (SumW),
    .ENT_W         (EntW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .samp_i      (samp_i),
    .base_len_i  (base_len_q),
    .win_start_i (win_start_q),
    .win_stop_i  (win_stop_q),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // finished records wait here while the back is busy dividing
  wce_fifo #(
    .WIDTH (EntW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  // back: baseline division, charge correction, result register
  wce_back #(
    .RECORD_LENGTH (RECORD_LENGTH),
    .SUM_W         (SumW),
    .ENT_W         (EntW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .base_len_i  (base_len_q),
    .win_start_i (win_start_q),
    .win_stop_i  (win_stop_q),
    .res_o       (res_o)
  );

endmodule
`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// streams waveform records into the charge extractor under a range of register
// settings, with bursty sample beats and a stalling result side, and checks
// every record result against a cycle-free predictor of baseline, extremes
// and charge
// ----------------------------------------------------------------------------
import wce_pkg::*;

class record_tracker;

  // register copy
  logic [CFG_W-1:0]           base_len;
  logic [CFG_W-1:0]           win_start;
  logic [CFG_W-1:0]           win_stop;

  // per-record running state
  logic [CFG_W-1:0]           sample_idx;
  logic signed [SAMPLE_W-1:0] run_min;
  logic signed [SAMPLE_W-1:0] run_max;
  logic signed [26:0]         base_sum;
  logic signed [26:0]         win_sum;

  wce_out_t                   pending_records[$];
  int                         record_count;
  int                         fail_count;

  function new();
    base_len     = BASE_LEN_RST;
    win_start    = WIN_START_RST;
    win_stop     = WIN_STOP_RST;
    record_count = 0;
    fail_count   = 0;
    clear_record();
  endfunction

  function void clear_record();
    sample_idx = '0;
    run_min    = MIN_START;
    run_max    = MAX_START;
    base_sum   = '0;
    win_sum    = '0;
  endfunction

  function void set_reg(input logic [PADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
    case (addr)
      REG_BASE_LEN:  base_len  = value;
      REG_WIN_START: win_start = value;
      REG_WIN_STOP:  win_stop  = value;
      default: ;
    endcase
  endfunction

  function logic [CFG_W-1:0] reg_value(input logic [PADDR_W-1:0] addr);
    case (addr)
      REG_BASE_LEN:  return base_len;
      REG_WIN_START: return win_start;
      REG_WIN_STOP:  return win_stop;
      default:       return '0;
    endcase
  endfunction

  function void flag(input string what, input longint want, input longint got);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s expected %0d got %0d", what, want, got);
  endfunction

  // accumulate one accepted sample beat, queue the record result on a last beat
  function void absorb_sample(input wce_in_t beat);
    longint   base;
    longint   span;
    longint   q;
    wce_out_t res;
    // samples past the record length touch nothing
    if (sample_idx < RECORD_LENGTH_DEF) begin
      if (beat.sample < run_min) run_min = beat.sample;
      if (beat.sample > run_max) run_max = beat.sample;
      if (sample_idx < base_len) base_sum += beat.sample;
      if (sample_idx >= win_start && sample_idx < win_stop) win_sum += beat.sample;
      sample_idx++;
    end
    if (!beat.last_sample) return;
    // zero baseline length leaves the baseline at zero
    base = 0;
    if (base_len != 0) base = (16 * longint'(base_sum)) / longint'(base_len);
    // reversed window still applies its negative span
    span = longint'(win_stop) - longint'(win_start);
    q    = 16 * longint'(win_sum) - span * base;
    if (q > 64'sd2147483647)  q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    res.baseline      = base[BASELINE_W-1:0];
    res.amplitude_min = run_min;
    res.amplitude_max = run_max;
    res.charge        = q[CHARGE_W-1:0];
    pending_records.push_back(res);
    clear_record();
  endfunction

  function void compare_record(input wce_out_t got);
    wce_out_t want;
    if (pending_records.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch: record result with none pending, charge %0d", got.charge);
      return;
    end
    want = pending_records.pop_front();
    if (got.baseline !== want.baseline)
      flag($sformatf("record %0d baseline", record_count), want.baseline, got.baseline);
    if (got.amplitude_min !== want.amplitude_min)
      flag($sformatf("record %0d amplitude_min", record_count),
           want.amplitude_min, got.amplitude_min);
    if (got.amplitude_max !== want.amplitude_max)
      flag($sformatf("record %0d amplitude_max", record_count),
           want.amplitude_max, got.amplitude_max);
    if (got.charge !== want.charge)
      flag($sformatf("record %0d charge", record_count), want.charge, got.charge);
    record_count++;
  endfunction

endclass

module testbench;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 11;
  // longest quiet stretch of a correct run is the long hold plus one division
  localparam int IDLE_LIMIT    = 5000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 48;
  localparam int PHASE_ITEMS   = 36;

  typedef enum int {WAVE_PULSE, WAVE_NOISE, WAVE_EXTREME} wave_e;
  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_e;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  wce_in_if  samp_if ();
  wce_out_if res_if ();

  record_tracker      tracker = new();
  logic [PADDR_W-1:0] reg_addrs [3] = '{REG_BASE_LEN, REG_WIN_START, REG_WIN_STOP};
  int                 idle_cycles = 0;
  bit                 hold_req = 1'b0;   // asks the receiver for one long hold-off
  bit                 steady = 1'b0;     // sender offers beats back to back
  int                 burst_left = 0;

  waveform_charge_extractor u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .samp_i  (samp_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // result side: every accepted beat is checked against the oldest pending record
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
      tracker.compare_record(res_if.data);
  end

  // watchdog: any handshake on either channel or the register port counts as progress
  always @(posedge clk_i) begin
    if ((samp_if.valid === 1'b1 && samp_if.ready === 1'b1) ||
        (res_if.valid === 1'b1 && res_if.ready === 1'b1) ||
        (psel === 1'b1 && penable === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: segments of open, random, periodic and sparse ready, plus one
  // long hold-off on request so that the record queue fills and the sample
  // side backs up
  initial begin : receiver
    rx_mode_e mode;
    int       seg;
    int       period;
    res_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        mode   = rx_mode_e'($urandom_range(0, 3));
        seg    = $urandom_range(16, 160);
        period = $urandom_range(2, 9);
        for (int k = 0; k < seg && !hold_req; k++) begin
          case (mode)
            RX_OPEN:     res_if.ready <= 1'b1;
            RX_RANDOM:   res_if.ready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: res_if.ready <= (k % period) != 0;
            default:     res_if.ready <= $urandom_range(0, 7) == 0;
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // one sample beat; outside steady stretches the sender works in bursts of
  // random length with random gaps between them
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic is_last);
    wce_in_t beat;
    int      gap;
    beat.sample      = value;
    beat.last_sample = is_last;
    if (!steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 32);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          samp_if.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
    end
    samp_if.valid <= 1'b1;
    samp_if.data  <= beat;
    do @(posedge clk_i); while (samp_if.ready !== 1'b1);
    tracker.absorb_sample(beat);
  endtask

  task automatic send_values(input int vals[$]);
    foreach (vals[k]) send_sample(SAMPLE_W'(vals[k]), k == vals.size() - 1);
  endtask

  // one record; a pulse record is a flat level with noise and a single pulse
  task automatic send_record(input int len, input wave_e style);
    int level;
    int pulse_at;
    int pulse_w;
    int amp;
    int v;
    level    = int'($urandom_range(0, 4000)) - 2000;
    pulse_at = $urandom_range(0, len - 1);
    pulse_w  = $urandom_range(1, 24);
    amp      = int'($urandom_range(0, 30000));
    if ($urandom_range(0, 3) != 0) amp = -amp;
    for (int i = 0; i < len; i++) begin
      case (style)
        WAVE_PULSE: begin
          v = level + int'($urandom_range(0, 16)) - 8;
          if (i >= pulse_at && i < pulse_at + pulse_w) v += amp;
        end
        WAVE_NOISE: v = int'($urandom_range(0, 65535)) - 32768;
        default:    v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      endcase
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      send_sample(SAMPLE_W'(v), i == len - 1);
    end
  endtask

  // mostly short records, a few longer ones, mostly pulse-shaped content
  task automatic random_records(input int budget);
    int    items;
    int    len;
    int    pick;
    wave_e style;
    items = 0;
    while (items < budget) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) len = $urandom_range(1, 4);
      else if (pick < 8) len = $urandom_range(5, 40);
      else len = $urandom_range(41, 120);
      pick = $urandom_range(0, 9);
      if (pick < 7) style = WAVE_PULSE;
      else if (pick < 9) style = WAVE_NOISE;
      else style = WAVE_EXTREME;
      send_record(len, style);
      items += len;
    end
  endtask

  // sender pauses until every pending record result has come back
  task automatic wait_for_results();
    samp_if.valid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending_records.size() != 0);
  endtask

  // setup and access cycle, then an idle gap with psel low so accesses never overlap
  task automatic apb_access(input logic is_write, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_registers();
    logic [PDATA_W-1:0] rdata;
    foreach (reg_addrs[k]) begin
      apb_access(1'b0, reg_addrs[k], '0, rdata);
      if (rdata[CFG_W-1:0] !== tracker.reg_value(reg_addrs[k]))
        tracker.flag($sformatf("register at 0x%0h", reg_addrs[k]),
                     tracker.reg_value(reg_addrs[k]), rdata[CFG_W-1:0]);
    end
  endtask

  // registers change only with the block idle: results drained, division done
  task automatic configure(input logic [CFG_W-1:0] base_len, input logic [CFG_W-1:0] win_lo,
                           input logic [CFG_W-1:0] win_hi);
    logic [CFG_W-1:0]   values [3];
    logic [PDATA_W-1:0] wdata;
    logic [PDATA_W-1:0] rdata;
    values = '{base_len, win_lo, win_hi};
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    foreach (reg_addrs[k]) begin
      // upper data bits carry noise, only the low field is kept
      wdata = $urandom;
      wdata[CFG_W-1:0] = values[k];
      apb_access(1'b1, reg_addrs[k], wdata, rdata);
      tracker.set_reg(reg_addrs[k], values[k]);
    end
    check_registers();
  endtask

  function automatic logic [CFG_W-1:0] pick_setting(input int upper);
    if ($urandom_range(0, 3) == 0) return CFG_W'($urandom);
    return CFG_W'($urandom_range(0, upper));
  endfunction

  initial begin : stimulus
    int vals[$];
    int items;
    int len;
    rst_ni        = 1'b0;
    samp_if.valid = 1'b0;
    samp_if.data  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values of the registers
    check_registers();

    // reset settings: baseline longer than these records, window beyond them
    vals = '{32767, -32768, 0, 1};
    send_values(vals);
    // every sample above the minimum start value
    vals = '{25000};
    send_values(vals);
    // every sample below the maximum start value
    vals = '{-25000, -30000};
    send_values(vals);
    // samples equal to both start values
    vals = '{20000, -20000};
    send_values(vals);
    // negative baseline truncates toward zero
    vals = '{-1, -1, -1};
    send_values(vals);
    vals = '{1};
    send_values(vals);

    // zero baseline length
    configure(0, 0, 4);
    vals = '{100, -200, 300, -400, 500};
    send_values(vals);

    // reversed window applies a negative span
    configure(3, 6, 2);
    vals = '{7, 8, 9, 10, 11, 12, 13, 14};
    send_values(vals);

    // extreme settings
    configure(0, 0, 2047);
    random_records(PHASE_ITEMS);
    configure(2047, 2047, 0);
    random_records(PHASE_ITEMS);
    configure(1, 0, 1);
    random_records(PHASE_ITEMS);

    for (int p = 0; p < 8; p++) begin
      configure(pick_setting(40), pick_setting(40), pick_setting(64));
      steady = $urandom_range(0, 3) == 0;
      if (p == 2) begin
        // long hold on the result side while tiny records keep coming
        steady   = 1'b1;
        hold_req = 1'b1;
        items    = 0;
        while (items < 60) begin
          len = $urandom_range(1, 3);
          send_record(len, WAVE_PULSE);
          items += len;
        end
      end else if (p == 5) begin
        random_records(PHASE_ITEMS / 2);
        wait_for_results();
        random_records(PHASE_ITEMS / 2);
      end else begin
        random_records(PHASE_ITEMS);
      end
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tracker.fail_count == 0 && tracker.pending_records.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
hdl/wce_pkg.sv
hdl/wce_intf.sv
hdl/wce_front.sv
hdl/wce_fifo.sv
hdl/wce_back.sv
hdl/waveform_charge_extractor.sv
bench/testbench.sv
